[hdl/bqf_pkg.sv]
// shared constants and types for the biquad filter section
package bqf_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int DELAY_BITS      = 48;
   localparam int COEF_BITS       = 32;
   localparam int GAIN_BITS       = 31;
   localparam int COEF_FRAC       = 28;
   localparam int DELAY_FRAC      = 32;
   localparam int SPLIT_BITS      = 24;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_ADDR_BITS   = 5;
   localparam int CSR_IDX_BITS    = 3;

   localparam logic        [GAIN_BITS-1:0] GAIN_RESET = 31'd156250;
   localparam logic signed [COEF_BITS-1:0] B1_RESET   = 32'sd536870912;
   localparam logic signed [COEF_BITS-1:0] B2_RESET   = 32'sd268435456;
   localparam logic signed [COEF_BITS-1:0] A1_RESET   = -32'sd518243217;
   localparam logic signed [COEF_BITS-1:0] A2_RESET   = 32'sd250432760;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_INVERSE_GAIN      = 3'd0,
      REG_FEEDFORWARD_PREV1 = 3'd1,
      REG_FEEDFORWARD_PREV2 = 3'd2,
      REG_FEEDBACK_PREV1    = 3'd3,
      REG_FEEDBACK_PREV2    = 3'd4
   } bqf_reg_type;

   typedef struct packed {
      logic        [GAIN_BITS-1:0] inverse_gain;
      logic signed [COEF_BITS-1:0] feedforward_prev1;
      logic signed [COEF_BITS-1:0] feedforward_prev2;
      logic signed [COEF_BITS-1:0] feedback_prev1;
      logic signed [COEF_BITS-1:0] feedback_prev2;
   } bqf_coef_type;

endpackage

[hdl/bqf_if.sv]
// word channels for the biquad filter section
interface bqf_req_if
   import bqf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqf_rsp_if
   import bqf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

[hdl/bqf_csr.sv]
// coefficient register file behind the apb-style port
module bqf_csr
   import bqf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output bqf_coef_type             coef
);

   bqf_coef_type coef_ff, coef_in;
   bqf_reg_type  reg_sel;
   logic         wr_en;

   assign pready  = 1'b1;
   assign reg_sel = bqf_reg_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign coef    = coef_ff;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_INVERSE_GAIN:      coef_in.inverse_gain      = pwdata[GAIN_BITS-1:0];
            REG_FEEDFORWARD_PREV1: coef_in.feedforward_prev1 = pwdata;
            REG_FEEDFORWARD_PREV2: coef_in.feedforward_prev2 = pwdata;
            REG_FEEDBACK_PREV1:    coef_in.feedback_prev1    = pwdata;
            REG_FEEDBACK_PREV2:    coef_in.feedback_prev2    = pwdata;
            default:               coef_in = coef_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_INVERSE_GAIN:      prdata = {1'b0, coef_ff.inverse_gain};
         REG_FEEDFORWARD_PREV1: prdata = coef_ff.feedforward_prev1;
         REG_FEEDFORWARD_PREV2: prdata = coef_ff.feedforward_prev2;
         REG_FEEDBACK_PREV1:    prdata = coef_ff.feedback_prev1;
         REG_FEEDBACK_PREV2:    prdata = coef_ff.feedback_prev2;
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.inverse_gain      <= GAIN_RESET;
         coef_ff.feedforward_prev1 <= B1_RESET;
         coef_ff.feedforward_prev2 <= B2_RESET;
         coef_ff.feedback_prev1    <= A1_RESET;
         coef_ff.feedback_prev2    <= A2_RESET;
      end else begin
         coef_ff <= coef_in;
      end
   end

endmodule

[hdl/bqf_datapath.sv]
// input register, single-pass biquad arithmetic, delay line and result register
module bqf_datapath
   import bqf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  bqf_coef_type coef,
   bqf_req_if.sink      req,
   bqf_rsp_if.source    rsp
);

   localparam int IN_SHIFT  = SAMPLE_BITS - 1 + COEF_FRAC - DELAY_FRAC;
   localparam int OUT_SHIFT = DELAY_FRAC - (SAMPLE_BITS - 1);
   localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
   localparam int XS_W      = PROD_W - IN_SHIFT;
   localparam int HI_W      = DELAY_BITS - SPLIT_BITS;
   localparam int Q_W       = HI_W + COEF_BITS;
   localparam int P_W       = SPLIT_BITS + COEF_BITS + 2;
   localparam int TERM_W    = P_W - 4;
   localparam int ACC_W     = TERM_W + 3;
   localparam int YR_W      = DELAY_BITS + 1;
   localparam int R_W       = YR_W - OUT_SHIFT;

   // round(a * c / 2^28), split into two narrow partial products
   function automatic logic signed [TERM_W-1:0] mul_coef(
      input logic signed [DELAY_BITS-1:0] a,
      input logic signed [COEF_BITS-1:0]  c
   );
      logic signed [HI_W-1:0]       hi;
      logic signed [SPLIT_BITS:0]   lo;
      logic signed [Q_W-1:0]        q;
      logic signed [P_W-1:0]        p;
      logic signed [P_W-1:0]        s;
      hi = a[DELAY_BITS-1:SPLIT_BITS];
      lo = {1'b0, a[SPLIT_BITS-1:0]};
      q  = hi * c;
      p  = lo * c + (P_W'(1) <<< (COEF_FRAC - 1));
      s  = $signed({{(P_W-Q_W){q[Q_W-1]}}, q}) + (p >>> SPLIT_BITS);
      return s[P_W-1:4];
   endfunction

   logic                          v1_ff, v1_in;
   logic                          v2_ff, v2_in;
   logic signed [SAMPLE_BITS-1:0] smp_ff;
   logic signed [DELAY_BITS-1:0]  xd1_ff, xd2_ff, yd1_ff, yd2_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff, out_in;
   logic                          clip_ff, clip_in;

   logic                          out_free, advance, take;
   logic signed [COEF_BITS-1:0]   gain_ext;
   logic signed [PROD_W-1:0]      xprod;
   logic signed [DELAY_BITS-1:0]  x_val, y_val;
   logic signed [ACC_W-1:0]       acc;
   logic                          acc_ovf;
   logic signed [YR_W-1:0]        yr;
   logic signed [R_W-1:0]         r_val;
   logic                          r_ovf;

   assign out_free  = !v2_ff || rsp.ready;
   assign advance   = v1_ff && out_free;
   assign req.ready = !v1_ff || out_free;
   assign take      = req.valid && req.ready;

   // input scaling, never wide enough to need saturation
   assign gain_ext = {1'b0, coef.inverse_gain};
   always_comb begin
      xprod = smp_ff * gain_ext + (PROD_W'(1) <<< (IN_SHIFT - 1));
      x_val = {{(DELAY_BITS-XS_W){xprod[PROD_W-1]}}, xprod[PROD_W-1:IN_SHIFT]};
   end

   always_comb begin
      acc = $signed({{(ACC_W-DELAY_BITS){x_val[DELAY_BITS-1]}}, x_val})
          + ACC_W'(mul_coef(xd1_ff, coef.feedforward_prev1))
          + ACC_W'(mul_coef(xd2_ff, coef.feedforward_prev2))
          - ACC_W'(mul_coef(yd1_ff, coef.feedback_prev1))
          - ACC_W'(mul_coef(yd2_ff, coef.feedback_prev2));
      acc_ovf = !((&acc[ACC_W-1:DELAY_BITS-1]) || !(|acc[ACC_W-1:DELAY_BITS-1]));
      if (acc_ovf) begin
         y_val = acc[ACC_W-1] ? {1'b1, {(DELAY_BITS-1){1'b0}}}
                              : {1'b0, {(DELAY_BITS-1){1'b1}}};
      end else begin
         y_val = acc[DELAY_BITS-1:0];
      end
   end

   always_comb begin
      yr    = {y_val[DELAY_BITS-1], y_val} + (YR_W'(1) <<< (OUT_SHIFT - 1));
      r_val = yr[YR_W-1:OUT_SHIFT];
      r_ovf = !((&r_val[R_W-1:SAMPLE_BITS-1]) || !(|r_val[R_W-1:SAMPLE_BITS-1]));
      clip_in = r_ovf;
      if (r_ovf) begin
         out_in = r_val[R_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                               : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
         out_in = r_val[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      v1_in = take ? 1'b1 : (advance ? 1'b0 : v1_ff);
      v2_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : v2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         xd1_ff <= '0;
         xd2_ff <= '0;
         yd1_ff <= '0;
         yd2_ff <= '0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         if (advance) begin
            xd2_ff <= xd1_ff;
            xd1_ff <= x_val;
            yd2_ff <= yd1_ff;
            yd1_ff <= y_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         smp_ff <= req.sample_in;
      end
      if (advance) begin
         out_ff  <= out_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp.valid      = v2_ff;
   assign rsp.sample_out = out_ff;
   assign rsp.clipped    = clip_ff;

endmodule

[hdl/biquad_iir_filter.sv]
// top level of the direct form i biquad filter section
// one second-order iir section in direct form i. each sample word taken on the req
// channel is scaled by inverse_gain, then y = x + b1*x1 + b2*x2 - a1*y1 - a2*y2 is
// formed with q4.28 coefficients and 48-bit q16.32 delay words, and the result goes
// out on the rsp channel rounded to the sample format, saturated, with clipped set
// when the output saturates. throughput is one word per clock while rsp keeps up:
// an input register feeds a single pass of arithmetic into a result register, and
// the feedback through the two y delay words closes within that pass, which also
// sets the clock limit. a word moves on once no result waits on rsp. while a finished
// word waits on rsp, the req side takes one more word into the input register and
// then holds off until rsp takes the waiting one. coefficients sit on the apb-style
// port at byte address 4*i and are only to be written while the filter is idle; the
// delay line clears on reset.
module biquad_iir_filter
   import bqf_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // coefficient port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   // sample word channels
   bqf_req_if.sink                  req_port,
   bqf_rsp_if.source                rsp_port
);

   // live coefficient set
   bqf_coef_type coef;

   // register file for gain and the four coefficients
   bqf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef)
   );

   // filter arithmetic, delay line and output word register
   bqf_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .coef  (coef),
      .req   (req_port),
      .rsp   (rsp_port)
   );

endmodule

[sim/biquad_iir_filter_test.sv]
// self-checking testbench for the direct form i biquad filter section
module biquad_iir_filter_test
   import bqf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB            = SAMPLE_BITS_DEF;
   // shift that takes sample times gain (q1.15 * q4.28) to the q16.32 delay format
   localparam int IN_SHIFT      = SB - 1 + COEF_FRAC - DELAY_FRAC;
   // shift that takes a q16.32 delay word back to the sample format
   localparam int OUT_SHIFT     = DELAY_FRAC - (SB - 1);
   localparam int REG_COUNT     = 5;
   localparam int SETTLE_CYCLES = 8;
   localparam int SET_COUNT     = 3;
   localparam int WORDS_PER_SET = 195;
   localparam int STALL_CYCLES  = 300;
   localparam int STALL_WORDS   = 40;

   typedef struct packed {
      logic signed [SB-1:0] sample_out;
      logic                 clipped;
   } filtered_word_type;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   bqf_req_if #(.SAMPLE_BITS(SB)) req_bus ();
   bqf_rsp_if #(.SAMPLE_BITS(SB)) rsp_bus ();

   biquad_iir_filter #(.SAMPLE_BITS(SB)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // own copy of the coefficient registers and the delay line
   bqf_coef_type                  coef_model;
   logic signed [DELAY_BITS-1:0]  scaled_hist1;
   logic signed [DELAY_BITS-1:0]  scaled_hist2;
   logic signed [DELAY_BITS-1:0]  out_hist1;
   logic signed [DELAY_BITS-1:0]  out_hist2;

   // filtered words still owed by the block, oldest first
   filtered_word_type             pending_words[$];

   int                            error_count;
   int                            send_idle_pct;
   int                            rsp_idle_pct;
   int                            stall_left;
   logic signed [SB-1:0]          last_sample;

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // hard stop well beyond the slowest legal run
   initial begin : run_limit
      #4ms;
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------------

   // clamp to a signed field of the given width, flagging when it bites
   function automatic longint saturate(input longint v, input int bits, output logic hit);
      longint hi;
      longint lo;
      hi  = (longint'(1) <<< (bits - 1)) - 1;
      lo  = -hi - 1;
      hit = 1'b0;
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      return v;
   endfunction

   // delay word times q4.28 coefficient, rounded half up back to q16.32
   function automatic longint coef_product(input logic signed [DELAY_BITS-1:0] hist,
                                           input logic signed [COEF_BITS-1:0] coef);
      logic signed [95:0] wide_hist;
      logic signed [95:0] wide_coef;
      logic signed [95:0] wide;
      wide_hist = hist;
      wide_coef = coef;
      wide      = (wide_hist * wide_coef + (96'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      return wide[63:0];
   endfunction

   // one sample through the section: updates the delay line, returns the output word
   function automatic filtered_word_type filter_sample(input logic signed [SB-1:0] smp);
      longint            scaled;
      longint            acc;
      longint            rounded;
      logic              hit;
      filtered_word_type word;
      scaled = longint'(smp) * longint'({1'b0, coef_model.inverse_gain});
      scaled = (scaled + (longint'(1) <<< (IN_SHIFT - 1))) >>> IN_SHIFT;
      scaled = saturate(scaled, DELAY_BITS, hit);
      acc = scaled
          + coef_product(scaled_hist1, coef_model.feedforward_prev1)
          + coef_product(scaled_hist2, coef_model.feedforward_prev2)
          - coef_product(out_hist1, coef_model.feedback_prev1)
          - coef_product(out_hist2, coef_model.feedback_prev2);
      // saturation of the accumulator is stored but does not raise clipped
      acc = saturate(acc, DELAY_BITS, hit);
      scaled_hist2 = scaled_hist1;
      scaled_hist1 = scaled[DELAY_BITS-1:0];
      out_hist2    = out_hist1;
      out_hist1    = acc[DELAY_BITS-1:0];
      rounded = (acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      rounded = saturate(rounded, SB, hit);
      word.sample_out = rounded[SB-1:0];
      word.clipped    = hit;
      return word;
   endfunction

   // register write as the block sees it: top bit of the gain dropped, unused slots ignored
   function automatic void apply_reg(input logic [CSR_IDX_BITS-1:0] idx,
                                     input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         REG_INVERSE_GAIN:      coef_model.inverse_gain      = data[GAIN_BITS-1:0];
         REG_FEEDFORWARD_PREV1: coef_model.feedforward_prev1 = data;
         REG_FEEDFORWARD_PREV2: coef_model.feedforward_prev2 = data;
         REG_FEEDBACK_PREV1:    coef_model.feedback_prev1    = data;
         REG_FEEDBACK_PREV2:    coef_model.feedback_prev2    = data;
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint want, input longint got);
      error_count++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
   endtask

   // every word taken from rsp is held against the oldest prediction
   always @(posedge clock) begin
      filtered_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected word, sample_out", 0, rsp_bus.sample_out);
         end else begin
            want = pending_words.pop_front();
            if (rsp_bus.sample_out !== want.sample_out)
               report_mismatch("sample_out", want.sample_out, rsp_bus.sample_out);
            if (rsp_bus.clipped !== want.clipped)
               report_mismatch("clipped", want.clipped, rsp_bus.clipped);
         end
      end
   end

   // rsp ready: random idling, or held low while a stall count runs down
   initial begin : rsp_ready_driver
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------

   // offer one sample word, idling beforehand at random; returns at the accepting edge
   // with valid still high so a following word can go straight out
   task automatic send_sample(input logic signed [SB-1:0] smp);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= smp;
      do @(posedge clock); while (!req_bus.ready);
      pending_words.push_back(filter_sample(smp));
      last_sample = smp;
   endtask

   // stop offering, let every owed word come out, then give the pipe time to settle
   task automatic await_idle();
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup, access, then idle so transfers never touch
   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      apply_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [CSR_IDX_BITS-1:0] idx,
                           output logic [CSR_DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data     = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // read every register back and hold it against the modelled value
   task automatic check_readback();
      logic [CSR_DATA_BITS-1:0] got;
      logic [CSR_DATA_BITS-1:0] want;
      for (int i = 0; i < REG_COUNT; i++) begin
         csr_read(CSR_IDX_BITS'(i), got);
         case (bqf_reg_type'(i))
            REG_INVERSE_GAIN:      want = {1'b0, coef_model.inverse_gain};
            REG_FEEDFORWARD_PREV1: want = coef_model.feedforward_prev1;
            REG_FEEDFORWARD_PREV2: want = coef_model.feedforward_prev2;
            REG_FEEDBACK_PREV1:    want = coef_model.feedback_prev1;
            default:               want = coef_model.feedback_prev2;
         endcase
         if (got !== want)
            report_mismatch($sformatf("register %0d readback", i), want, got);
      end
   endtask

   task automatic load_coefficients(input logic [CSR_DATA_BITS-1:0] gain,
                                    input logic [CSR_DATA_BITS-1:0] b1,
                                    input logic [CSR_DATA_BITS-1:0] b2,
                                    input logic [CSR_DATA_BITS-1:0] a1,
                                    input logic [CSR_DATA_BITS-1:0] a2);
      csr_write(REG_INVERSE_GAIN, gain);
      csr_write(REG_FEEDFORWARD_PREV1, b1);
      csr_write(REG_FEEDFORWARD_PREV2, b2);
      csr_write(REG_FEEDBACK_PREV1, a1);
      csr_write(REG_FEEDBACK_PREV2, a2);
   endtask

   // mostly stable pole pairs with sensible gains, now and then extremes or pure noise
   task automatic load_random_coefficients();
      int                       kind;
      int                       pole2;
      int                       span;
      logic [CSR_DATA_BITS-1:0] gain;
      logic [CSR_DATA_BITS-1:0] b1;
      logic [CSR_DATA_BITS-1:0] b2;
      logic [CSR_DATA_BITS-1:0] a1;
      logic [CSR_DATA_BITS-1:0] a2;
      kind = $urandom_range(9);
      gain = $urandom;
      b1   = $urandom;
      b2   = $urandom;
      a1   = $urandom;
      a2   = $urandom;
      if (kind < 7) begin
         // inside the stability triangle: |a2| < 0.9, |a1| < 1 + a2
         pole2 = int'($urandom_range(483183820)) - 241591910;
         span  = 268435456 + pole2;
         a2    = pole2;
         a1    = int'($urandom_range(2 * span - 2)) - (span - 1);
         b1    = int'($urandom_range(1073741824)) - 536870912;
         b2    = int'($urandom_range(1073741824)) - 536870912;
         gain  = $urandom_range(268435456) >> $urandom_range(10);
      end else if (kind == 7) begin
         gain = 32'h7fff_ffff;
      end else if (kind == 8) begin
         gain = '0;
      end
      load_coefficients(gain, b1, b2, a1, a2);
   endtask

   // full-range words mostly, with extremes, silence, quiet noise and held values mixed in
   function automatic logic signed [SB-1:0] random_sample();
      logic signed [SB-1:0] smp;
      case ($urandom_range(9))
         6:       smp = $urandom_range(1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
         7:       smp = '0;
         8:       smp = SB'(int'($urandom_range(511)) - 256);
         9:       smp = last_sample;
         default: smp = SB'($urandom);
      endcase
      return smp;
   endfunction

   // ---------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------

   // reset coefficients read back, and the cleared delay line seen through an impulse
   task automatic test_reset_state();
      check_readback();
      send_sample(16'sh7fff);
      send_sample('0);
      send_sample('0);
      send_sample(16'sh8000);
      send_sample('0);
      send_sample(16'sh0001);
      send_sample(-16'sh0001);
      await_idle();
   endtask

   // every register written, an over-wide gain trimmed, writes past the last slot dropped
   task automatic test_register_map();
      load_coefficients(32'hffff_ffff, '0, '0, '0, '0);
      for (int i = REG_COUNT; i < (1 << CSR_IDX_BITS); i++)
         csr_write(CSR_IDX_BITS'(i), $urandom);
      check_readback();
   endtask

   // gain near eight with no feedback: the output clips at both rails
   task automatic test_output_clipping();
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      send_sample(16'sd4095);
      send_sample(16'sd4096);
      send_sample(-16'sd4097);
      send_sample('0);
      await_idle();
   endtask

   // extreme coefficients drive the accumulator into its 48-bit limits
   task automatic test_accumulator_saturation();
      load_coefficients(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                        32'h8000_0000, 32'h7fff_ffff);
      repeat (4) send_sample(16'sh7fff);
      repeat (4) send_sample(16'sh8000);
      await_idle();
      load_coefficients(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h8000_0000);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      await_idle();
      // zero gain: only the saturated history keeps the output moving
      csr_write(REG_INVERSE_GAIN, '0);
      send_sample(16'sh7fff);
      send_sample(16'sh8000);
      await_idle();
   endtask

   // rsp held off for a long stretch while words keep coming, so req backs up
   task automatic test_backpressure();
      int saved_pct;
      saved_pct     = send_idle_pct;
      send_idle_pct = 0;
      load_coefficients(32'd156250, 32'sd536870912, 32'sd268435456,
                        -32'sd518243217, 32'sd250432760);
      stall_left = STALL_CYCLES;
      repeat (STALL_WORDS) send_sample(random_sample());
      // sender waits for every owed word before going on
      await_idle();
      send_idle_pct = saved_pct;
   endtask

   task automatic test_random_traffic(input int send_pct, input int rsp_pct);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      repeat (SET_COUNT) begin
         load_random_coefficients();
         repeat (WORDS_PER_SET) send_sample(random_sample());
         await_idle();
      end
   endtask

   // ---------------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------------

   initial begin : test_sequence
      reset             <= 1'b1;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.sample_in <= '0;
      error_count   = 0;
      send_idle_pct = 24;
      rsp_idle_pct  = 75;
      stall_left    = 0;
      last_sample   = '0;
      // state after reset
      coef_model.inverse_gain      = GAIN_RESET;
      coef_model.feedforward_prev1 = B1_RESET;
      coef_model.feedforward_prev2 = B2_RESET;
      coef_model.feedback_prev1    = A1_RESET;
      coef_model.feedback_prev2    = A2_RESET;
      scaled_hist1 = '0;
      scaled_hist2 = '0;
      out_hist1    = '0;
      out_hist2    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_register_map();
      test_output_clipping();
      test_accumulator_saturation();
      test_backpressure();
      // sender idle a quarter of the time against a slow receiver, then swapped, then flat out
      test_random_traffic(24, 75);
      test_random_traffic(75, 24);
      test_random_traffic(0, 0);

      await_idle();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
